// File: src/tgp_pkg.sv
// Package with the shared types and constants of the tile grid placement block.
`default_nettype none
package tgp_pkg;

  localparam int unsigned DW = 16;
  localparam int unsigned DS_W = 5;
  localparam int unsigned CNT_W = 4;

  typedef enum logic [2:0] {
    S_CW,
    S_CH,
    S_COLS,
    S_ROWS,
    S_MUL,
    S_ORG,
    S_IDLE
  } lay_state_t;

  typedef enum logic [2:0] {
    REG_FRAME_W  = 3'd0,
    REG_FRAME_H  = 3'd1,
    REG_DOWNSCL  = 3'd2,
    REG_FIX_COLS = 3'd3,
    REG_FIX_ROWS = 3'd4,
    REG_SCREEN_W = 3'd5,
    REG_SCREEN_H = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  localparam logic [DW-1:0]   RST_FRAME_W  = 16'd640;
  localparam logic [DW-1:0]   RST_FRAME_H  = 16'd400;
  localparam logic [DS_W-1:0] RST_DOWNSCL  = 5'd3;
  localparam logic [DW-1:0]   RST_SCREEN_W = 16'd1920;
  localparam logic [DW-1:0]   RST_SCREEN_H = 16'd1080;

  localparam int unsigned LATENCY = 2 * DW + 2;

  typedef struct packed {
    logic          vld;
    logic [DW-1:0] dvd;
    logic [DW-1:0] side;
  } div_req_t;

  typedef struct packed {
    logic          vld;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
    logic [DW-1:0] side;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/tile_grid_placement.sv
// Top level of the tile grid placement block with layout sequencer and item pipeline.
`default_nettype none
// A request carries a tile index and yields one result with the tile's screen position and the
// grid size in use; one request may be issued every cycle while busy is low, and the result
// strobe out_valid cannot be held off. The request passes through two 16-stage pipelined
// dividers (index by columns, then quotient by rows), a multiply stage and an add stage. After
// reset and after every register write, a serial divider recomputes the cell size, grid size
// and grid origin, during which busy is high.
module tile_grid_placement (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_tile_index,
  output logic             out_valid,
  output logic [15:0]      out_pos_x,
  output logic [15:0]      out_pos_y,
  output logic [15:0]      out_columns_used,
  output logic [15:0]      out_rows_used,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tgp_pkg::*;

  logic [DW-1:0]   frame_w_r, frame_h_r, fix_cols_r, fix_rows_r, screen_w_r, screen_h_r;
  logic [DS_W-1:0] downscl_r;
  logic            wr_en;
  reg_idx_t        widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r  <= RST_FRAME_W;
      frame_h_r  <= RST_FRAME_H;
      downscl_r  <= RST_DOWNSCL;
      fix_cols_r <= '0;
      fix_rows_r <= '0;
      screen_w_r <= RST_SCREEN_W;
      screen_h_r <= RST_SCREEN_H;
    end else if (wr_en) begin
      unique case (widx)
        REG_FRAME_W:  frame_w_r  <= pwdata[DW-1:0];
        REG_FRAME_H:  frame_h_r  <= pwdata[DW-1:0];
        REG_DOWNSCL:  downscl_r  <= pwdata[DS_W-1:0];
        REG_FIX_COLS: fix_cols_r <= pwdata[DW-1:0];
        REG_FIX_ROWS: fix_rows_r <= pwdata[DW-1:0];
        REG_SCREEN_W: screen_w_r <= pwdata[DW-1:0];
        REG_SCREEN_H: screen_h_r <= pwdata[DW-1:0];
        REG_NONE: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_FRAME_W:  prdata = {16'b0, frame_w_r};
      REG_FRAME_H:  prdata = {16'b0, frame_h_r};
      REG_DOWNSCL:  prdata = {27'b0, downscl_r};
      REG_FIX_COLS: prdata = {16'b0, fix_cols_r};
      REG_FIX_ROWS: prdata = {16'b0, fix_rows_r};
      REG_SCREEN_W: prdata = {16'b0, screen_w_r};
      REG_SCREEN_H: prdata = {16'b0, screen_h_r};
      REG_NONE:     prdata = '0;
    endcase
  end

  lay_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]   rem_r, dq_r;
  logic [DW-1:0]   cw_r, ch_r, cols_r, rows_r, x0_r, y0_r;
  logic [DW:0]     px_r, py_r;
  logic [DW-1:0]   sdvd, sdvs, rem_in, dq_in, q_new, q_clamp;
  logic [DW:0]     rem_sh;
  logic            ge, last, auto_lay;
  logic [DS_W-1:0] ds_eff;

  assign last     = cnt_r == CNT_W'(DW - 1);
  assign auto_lay = (fix_cols_r == '0) || (fix_rows_r == '0);
  assign ds_eff   = (downscl_r == '0) ? DS_W'(1) : downscl_r;

  always_comb begin
    state_nxt = state_r;
    priority if (wr_en) begin
      state_nxt = S_CW;
    end else begin
      unique case (state_r)
        S_CW:   if (last) state_nxt = S_CH;
        S_CH:   if (last) state_nxt = S_COLS;
        S_COLS: if (last) state_nxt = S_ROWS;
        S_ROWS: if (last) state_nxt = S_MUL;
        S_MUL:  state_nxt = S_ORG;
        S_ORG:  state_nxt = S_IDLE;
        S_IDLE: state_nxt = S_IDLE;
        default: state_nxt = S_CW;
      endcase
    end
  end

  always_comb begin
    busy = 1'b1;
    sdvd = frame_w_r;
    sdvs = {11'b0, ds_eff};
    unique case (state_r)
      S_CW:   begin sdvd = frame_w_r;  sdvs = {11'b0, ds_eff}; end
      S_CH:   begin sdvd = frame_h_r;  sdvs = {11'b0, ds_eff}; end
      S_COLS: begin sdvd = screen_w_r; sdvs = cw_r; end
      S_ROWS: begin sdvd = screen_h_r; sdvs = ch_r; end
      S_MUL, S_ORG: busy = 1'b1;
      S_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  assign rem_in  = (cnt_r == '0) ? '0 : rem_r;
  assign dq_in   = (cnt_r == '0) ? sdvd : dq_r;
  assign rem_sh  = {rem_in, dq_in[DW-1]};
  assign ge      = rem_sh >= {1'b0, sdvs};
  assign q_new   = {dq_in[DW-2:0], ge};
  assign q_clamp = (q_new == '0) ? DW'(1) : q_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CW;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en || state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
    rem_r <= ge ? DW'(rem_sh - {1'b0, sdvs}) : rem_sh[DW-1:0];
    dq_r  <= q_new;
    if (last && state_r == S_CW) cw_r <= q_clamp;
    if (last && state_r == S_CH) ch_r <= q_clamp;
    if (last && state_r == S_COLS) cols_r <= auto_lay ? q_clamp : fix_cols_r;
    if (last && state_r == S_ROWS) rows_r <= auto_lay ? q_clamp : fix_rows_r;
    if (state_r == S_MUL) begin
      px_r <= 17'(32'(cw_r) * 32'(cols_r));
      py_r <= 17'(32'(ch_r) * 32'(rows_r));
    end
    if (state_r == S_ORG) begin
      x0_r <= DW'(({1'b0, screen_w_r} - px_r) >> 1);
      y0_r <= DW'(({1'b0, screen_h_r} - py_r) >> 1);
    end
  end

  div_req_t req_a, req_b;
  div_rsp_t rsp_a, rsp_b;

  assign req_a.vld  = start && !busy;
  assign req_a.dvd  = in_tile_index;
  assign req_a.side = '0;

  tgp_div_pipe u_div_col (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_a),
    .dvs   (cols_r),
    .rsp   (rsp_a)
  );

  assign req_b.vld  = rsp_a.vld;
  assign req_b.dvd  = rsp_a.quo;
  assign req_b.side = rsp_a.rem;

  tgp_div_pipe u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_b),
    .dvs   (rows_r),
    .rsp   (rsp_b)
  );

  logic          mv_r;
  logic [DW-1:0] mx_r, my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mv_r      <= rsp_b.vld;
      out_valid <= mv_r;
    end
    mx_r             <= DW'(32'(rsp_b.side) * 32'(cw_r));
    my_r             <= DW'(32'(rsp_b.rem) * 32'(ch_r));
    out_pos_x        <= x0_r + mx_r;
    out_pos_y        <= y0_r + my_r;
    out_columns_used <= cols_r;
    out_rows_used    <= rows_r;
  end

  property p_write_busy;
    @(posedge clk) disable iff (!rst_n) wr_en |=> busy;
  endproperty
  a_write_busy: assert property (p_write_busy) else $error("not busy after register write");

  property p_latency;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##34 out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("result missing after request");

  property p_counts_nonzero;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_columns_used != '0 && out_rows_used != '0);
  endproperty
  a_counts_nonzero: assert property (p_counts_nonzero) else $error("zero grid size");

endmodule
`default_nettype wire

// File: src/tgp_div_pipe.sv
// Pipelined restoring divider that retires one quotient bit per stage.
`default_nettype none
module tgp_div_pipe (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tgp_pkg::div_req_t req,
  input  wire logic [15:0]      dvs,
  output tgp_pkg::div_rsp_t     rsp
);
  import tgp_pkg::*;

  logic          vld_r  [DW];
  logic [DW-1:0] rem_r  [DW];
  logic [DW-1:0] dq_r   [DW];
  logic [DW-1:0] side_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dq_in;
    logic [DW-1:0] side_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = req.vld;
      assign rem_in  = '0;
      assign dq_in   = req.dvd;
      assign side_in = req.side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dq_in   = dq_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rem_sh = {rem_in, dq_in[DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= ge ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
      dq_r[k]   <= {dq_in[DW-2:0], ge};
      side_r[k] <= side_in;
    end
  end

  assign rsp.vld  = vld_r[DW-1];
  assign rsp.quo  = dq_r[DW-1];
  assign rsp.rem  = rem_r[DW-1];
  assign rsp.side = side_r[DW-1];

  property p_rem_below_dvs;
    @(posedge clk) disable iff (!rst_n)
      (rsp.vld && $stable(dvs) && dvs != '0) |-> (rsp.rem < dvs);
  endproperty
  a_rem_below_dvs: assert property (p_rem_below_dvs) else $error("remainder not below divisor");

  property p_vld_travels;
    @(posedge clk) disable iff (!rst_n) vld_r[0] |=> vld_r[1];
  endproperty
  a_vld_travels: assert property (p_vld_travels) else $error("valid bit lost in divider");

  property p_no_spurious;
    @(posedge clk) disable iff (!rst_n) (!vld_r[0] && rst_n) |=> !vld_r[1];
  endproperty
  a_no_spurious: assert property (p_no_spurious) else $error("valid bit invented in divider");

endmodule
`default_nettype wire
